[hdl/olt_pkg.sv]
// ----------------------------------------------------------------------------
// olt_pkg
// Shared types, codes and defaults for the order lifecycle table.
// ----------------------------------------------------------------------------
package olt_pkg;

    localparam int ORDER_SLOTS_DEF   = 64;
    localparam int PENDING_SLOTS_DEF = 16;

    typedef enum logic [2:0] {
        K_INSERT  = 3'd0,
        K_REQUEST = 3'd1,
        K_ACK     = 3'd2,
        K_REJECT  = 3'd3,
        K_FILL    = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_NEG_QTY   = 3'd5,
        ST_OVERFILL  = 3'd6,
        ST_ACK_STATE = 3'd7
    } status_t;

    typedef struct packed {
        logic [30:0] id;
        logic [30:0] price;
        logic [30:0] qty;
        logic        side;
        logic        acked;
    } order_ent_t;

    typedef struct packed {
        logic [30:0]        new_id;
        logic [30:0]        old_id;
        logic signed [31:0] delta;
    } pend_ent_t;

    typedef struct packed {
        logic load;
        logic p_rd;
        logic o_rd;
        logic decide;
    } cmd_t;

    typedef struct packed {
        logic p_last;
        logic o_last;
        logic out_free;
    } stat_t;

endpackage

[hdl/order_lifecycle_table.sv]
// ----------------------------------------------------------------------------
// order_lifecycle_table
// Live order table with pending replacements; one result word per event.
// ----------------------------------------------------------------------------
// Each word is captured, then the pending table and the order table are scanned
//   one entry per cycle, and the result is written in the decide state, which
//   waits while a stalled result holds the output register. A new word is taken
//   only after decide, but while the previous result still waits in that register.
// Reset: asynchronous, active low; clears all order and pending valid bits,
//   no clearing pass is needed.
module order_lifecycle_table #(
    parameter int ORDER_SLOTS   = olt_pkg::ORDER_SLOTS_DEF,
    parameter int PENDING_SLOTS = olt_pkg::PENDING_SLOTS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         kind,
    input  logic [30:0]        order_id,
    input  logic [30:0]        old_id,
    input  logic [30:0]        price,
    input  logic signed [31:0] quantity,
    input  logic               buy_side,
    input  logic               start_acked,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               ok,
    output logic [2:0]         status,
    output logic [30:0]        remaining,
    output logic               side_out
);
    import olt_pkg::*;

    // command and status between sequencer and datapath
    cmd_t  cmd;
    stat_t st;

    // sequencer: idle, pending scan and drain, order scan and drain, decide
    olt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    // datapath: both tables, lowest-index search, update and result word
    olt_dp #(
        .ORDER_SLOTS   (ORDER_SLOTS),
        .PENDING_SLOTS (PENDING_SLOTS)
    ) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .kind        (kind),
        .order_id    (order_id),
        .old_id      (old_id),
        .price       (price),
        .quantity    (quantity),
        .buy_side    (buy_side),
        .start_acked (start_acked),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .ok          (ok),
        .status      (status),
        .remaining   (remaining),
        .side_out    (side_out)
    );

endmodule

[hdl/olt_ctrl.sv]
// ----------------------------------------------------------------------------
// olt_ctrl
// Sequencer: load a word, scan the pending table, scan the order table,
// then decide and write back.
// ----------------------------------------------------------------------------
module olt_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  olt_pkg::stat_t st,
    output olt_pkg::cmd_t  cmd
);
    import olt_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_PSCAN  = 6'b000010,
        S_PDRAIN = 6'b000100,
        S_OSCAN  = 6'b001000,
        S_ODRAIN = 6'b010000,
        S_DECIDE = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_valid) state_next = S_PSCAN;
            S_PSCAN:  if (st.p_last) state_next = S_PDRAIN;
            S_PDRAIN: state_next = S_OSCAN;
            S_OSCAN:  if (st.o_last) state_next = S_ODRAIN;
            S_ODRAIN: state_next = S_DECIDE;
            S_DECIDE: if (st.out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign cmd.load   = (state_reg == S_IDLE) && in_valid;
    assign cmd.p_rd   = (state_reg == S_PSCAN);
    assign cmd.o_rd   = (state_reg == S_OSCAN);
    assign cmd.decide = (state_reg == S_DECIDE) && st.out_free;

    a_decide_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.decide |=> (state_reg == S_IDLE))
        else $error("decide did not return to idle");
    a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.p_rd || cmd.o_rd) |-> in_stall)
        else $error("scan while accepting");
    a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == S_PSCAN))
        else $error("load did not start the pending scan");

endmodule

[hdl/olt_dp.sv]
// ----------------------------------------------------------------------------
// olt_dp
// Datapath: order and pending memories, scan compare, decision and result.
// ----------------------------------------------------------------------------
module olt_dp #(
    parameter int ORDER_SLOTS   = olt_pkg::ORDER_SLOTS_DEF,
    parameter int PENDING_SLOTS = olt_pkg::PENDING_SLOTS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  olt_pkg::cmd_t      cmd,
    output olt_pkg::stat_t     st,
    input  logic [2:0]         kind,
    input  logic [30:0]        order_id,
    input  logic [30:0]        old_id,
    input  logic [30:0]        price,
    input  logic signed [31:0] quantity,
    input  logic               buy_side,
    input  logic               start_acked,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               ok,
    output logic [2:0]         status,
    output logic [30:0]        remaining,
    output logic               side_out
);
    import olt_pkg::*;

    localparam int OW = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
    localparam int PW = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;

    // memories and their valid bits
    order_ent_t order_mem [ORDER_SLOTS];
    pend_ent_t  pend_mem  [PENDING_SLOTS];
    logic [ORDER_SLOTS-1:0]   o_valid_reg;
    logic [PENDING_SLOTS-1:0] p_valid_reg;

    // captured word
    kind_t              kind_reg;
    logic [30:0]        id_reg, old_reg, price_reg;
    logic signed [31:0] qty_reg;
    logic               side_reg, acked_reg;

    // scan pipeline
    logic [PW-1:0] p_addr_reg, p_idx_reg;
    logic [OW-1:0] o_addr_reg, o_idx_reg;
    logic          p_cmp_reg, o_cmp_reg;
    pend_ent_t     p_rd_reg;
    order_ent_t    o_rd_reg;

    // scan findings
    logic          pn_found, po_found, pf_found, sid_found, skey_found, sf_found;
    logic [PW-1:0] pn_idx, po_idx, pf_idx;
    logic [OW-1:0] sid_idx, skey_idx, sf_idx;
    logic [30:0]        pn_old;
    logic signed [31:0] pn_delta;
    order_ent_t    sid_ent, skey_ent;
    logic [PENDING_SLOTS-1:0] rm_mask;
    logic [30:0]   o_key;

    // result register
    logic          out_valid_reg;
    status_t       res_status_reg;
    logic [30:0]   res_rem_reg;
    logic          res_side_reg;

    assign o_key       = (kind_reg == K_ACK) ? pn_old : old_reg;
    assign st.p_last   = (p_addr_reg == PW'(PENDING_SLOTS - 1));
    assign st.o_last   = (o_addr_reg == OW'(ORDER_SLOTS - 1));
    assign st.out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= kind_t'(kind);
            id_reg    <= order_id;
            old_reg   <= old_id;
            price_reg <= price;
            qty_reg   <= quantity;
            side_reg  <= buy_side;
            acked_reg <= start_acked;
        end
        if (cmd.p_rd)
        begin
            p_rd_reg  <= pend_mem[p_addr_reg];
            p_idx_reg <= p_addr_reg;
        end
        if (cmd.o_rd)
        begin
            o_rd_reg  <= order_mem[o_addr_reg];
            o_idx_reg <= o_addr_reg;
        end
    end

    // scan control and lowest-index search
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_addr_reg <= '0;
            o_addr_reg <= '0;
            p_cmp_reg  <= 1'b0;
            o_cmp_reg  <= 1'b0;
            pn_found   <= 1'b0;
            po_found   <= 1'b0;
            pf_found   <= 1'b0;
            sid_found  <= 1'b0;
            skey_found <= 1'b0;
            sf_found   <= 1'b0;
            rm_mask    <= '0;
        end
        else
        begin
            p_cmp_reg <= cmd.p_rd;
            o_cmp_reg <= cmd.o_rd;
            if (cmd.load)
            begin
                p_addr_reg <= '0;
                o_addr_reg <= '0;
                pn_found   <= 1'b0;
                po_found   <= 1'b0;
                pf_found   <= 1'b0;
                sid_found  <= 1'b0;
                skey_found <= 1'b0;
                sf_found   <= 1'b0;
                rm_mask    <= '0;
            end
            if (cmd.p_rd)
                p_addr_reg <= p_addr_reg + PW'(1);
            if (cmd.o_rd)
                o_addr_reg <= o_addr_reg + OW'(1);
            if (p_cmp_reg)
            begin
                if (p_valid_reg[p_idx_reg])
                begin
                    if (!pn_found && p_rd_reg.new_id == id_reg)
                    begin
                        pn_found <= 1'b1;
                        pn_idx   <= p_idx_reg;
                        pn_old   <= p_rd_reg.old_id;
                        pn_delta <= p_rd_reg.delta;
                    end
                    if (!po_found && p_rd_reg.old_id == old_reg)
                    begin
                        po_found <= 1'b1;
                        po_idx   <= p_idx_reg;
                    end
                    if (p_rd_reg.old_id == id_reg)
                        rm_mask[p_idx_reg] <= 1'b1;
                end
                else if (!pf_found)
                begin
                    pf_found <= 1'b1;
                    pf_idx   <= p_idx_reg;
                end
            end
            if (o_cmp_reg)
            begin
                if (o_valid_reg[o_idx_reg])
                begin
                    if (!sid_found && o_rd_reg.id == id_reg)
                    begin
                        sid_found <= 1'b1;
                        sid_idx   <= o_idx_reg;
                        sid_ent   <= o_rd_reg;
                    end
                    if (!skey_found && o_rd_reg.id == o_key)
                    begin
                        skey_found <= 1'b1;
                        skey_idx   <= o_idx_reg;
                        skey_ent   <= o_rd_reg;
                    end
                end
                else if (!sf_found)
                begin
                    sf_found <= 1'b1;
                    sf_idx   <= o_idx_reg;
                end
            end
        end
    end

    // decision
    logic signed [31:0] delta_sel;
    logic signed [33:0] sum_w, left_w;
    logic               sum_le0, sum_big;
    status_t            dec_status;
    logic [30:0]        dec_rem;
    logic               dec_side;
    logic               o_we, o_vset, o_vclr, p_we, p_vclr, p_mask_clr;
    logic [OW-1:0]      o_wa;
    logic [PW-1:0]      p_wa, p_ca;
    order_ent_t         o_wd;
    pend_ent_t          p_wd;

    assign delta_sel = (kind_reg == K_ACK) ? pn_delta : qty_reg;
    assign sum_w     = $signed({3'b000, skey_ent.qty}) + 34'(delta_sel);
    assign left_w    = $signed({3'b000, sid_ent.qty}) - 34'(qty_reg);
    assign sum_le0   = sum_w[33] || (sum_w == '0);
    assign sum_big   = !sum_w[33] && (sum_w[32:31] != 2'b00);

    always_comb
    begin
        dec_status = ST_OK;
        dec_rem    = '0;
        dec_side   = 1'b0;
        o_we       = 1'b0;
        o_vset     = 1'b0;
        o_vclr     = 1'b0;
        o_wa       = sid_idx;
        o_wd       = sid_ent;
        p_we       = 1'b0;
        p_vclr     = 1'b0;
        p_mask_clr = 1'b0;
        p_wa       = pf_idx;
        p_ca       = pn_idx;
        p_wd       = '{new_id: id_reg, old_id: old_reg, delta: qty_reg};
        unique case (kind_reg)
            K_INSERT:
            begin
                if (qty_reg[31])
                    dec_status = ST_NEG_QTY;
                else if (sid_found)
                    dec_status = ST_DUPLICATE;
                else if (!sf_found)
                    dec_status = ST_FULL;
                else
                begin
                    o_we   = 1'b1;
                    o_vset = 1'b1;
                    o_wa   = sf_idx;
                    o_wd   = '{id: id_reg, price: price_reg, qty: qty_reg[30:0],
                               side: side_reg, acked: acked_reg};
                end
            end
            K_REQUEST:
            begin
                if (!skey_found)
                    dec_status = ST_NOT_FOUND;
                else if (sum_le0)
                    dec_status = ST_EMPTY;
                else if (sum_big)
                    dec_status = ST_OVERFILL;
                else if (pn_found || sid_found)
                    dec_status = ST_DUPLICATE;
                else if (!po_found && !pf_found)
                    dec_status = ST_FULL;
                else
                begin
                    p_we = 1'b1;
                    p_wa = po_found ? po_idx : pf_idx;
                end
            end
            K_ACK:
            begin
                if (sid_found)
                begin
                    o_we       = 1'b1;
                    o_wd.acked = 1'b1;
                end
                else if (!pn_found || !skey_found)
                    dec_status = ST_NOT_FOUND;
                else if (sum_le0)
                    dec_status = ST_EMPTY;
                else if (sum_big)
                    dec_status = ST_OVERFILL;
                else
                begin
                    // rename the old order and drop the pending entry
                    o_we     = 1'b1;
                    o_wa     = skey_idx;
                    o_wd     = skey_ent;
                    o_wd.id  = id_reg;
                    o_wd.qty = sum_w[30:0];
                    p_vclr   = 1'b1;
                end
            end
            K_REJECT:
            begin
                if (sid_found && !sid_ent.acked)
                begin
                    o_vclr     = 1'b1;
                    p_mask_clr = 1'b1;
                end
                else if (pn_found)
                    p_vclr = 1'b1;
                else if (sid_found)
                    dec_status = ST_ACK_STATE;
                else
                    dec_status = ST_NOT_FOUND;
            end
            K_FILL:
            begin
                if (qty_reg[31])
                    dec_status = ST_NEG_QTY;
                else if (!sid_found)
                    dec_status = ST_NOT_FOUND;
                else if (!sid_ent.acked)
                    dec_status = ST_ACK_STATE;
                else if (left_w[33])
                    dec_status = ST_OVERFILL;
                else
                begin
                    dec_rem  = left_w[30:0];
                    dec_side = sid_ent.side;
                    if (left_w == '0)
                    begin
                        o_vclr     = 1'b1;
                        p_mask_clr = 1'b1;
                    end
                    else
                    begin
                        o_we       = 1'b1;
                        o_wd.qty   = left_w[30:0];
                    end
                end
            end
            default: dec_status = ST_NOT_FOUND;
        endcase
    end

    // memory writes
    always_ff @(posedge clk)
    begin
        if (cmd.decide && o_we)
            order_mem[o_wa] <= o_wd;
        if (cmd.decide && p_we)
            pend_mem[p_wa] <= p_wd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= '0;
            p_valid_reg <= '0;
        end
        else if (cmd.decide)
        begin
            if (o_vset)
                o_valid_reg[o_wa] <= 1'b1;
            if (o_vclr)
                o_valid_reg[sid_idx] <= 1'b0;
            if (p_we)
                p_valid_reg[p_wa] <= 1'b1;
            if (p_vclr)
                p_valid_reg[p_ca] <= 1'b0;
            if (p_mask_clr)
                p_valid_reg <= p_valid_reg & ~rm_mask;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.decide)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.decide)
        begin
            res_status_reg <= dec_status;
            res_rem_reg    <= dec_rem;
            res_side_reg   <= dec_side;
        end
    end

    assign out_valid = out_valid_reg;
    assign ok        = (res_status_reg == ST_OK);
    assign status    = res_status_reg;
    assign remaining = res_rem_reg;
    assign side_out  = res_side_reg;

    a_fail_no_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !ok) |-> (remaining == '0 && !side_out))
        else $error("failed word carries fill data");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> !cmd.decide)
        else $error("result overwritten while stalled");
    a_insert_needs_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.decide && o_vset) |-> !o_valid_reg[o_wa])
        else $error("insert into a live slot");

endmodule
